// ===== rtl/core/gtog_pkg.sv =====
// gtog_pkg: widths, fixed-point constants, profile and arctangent tables,
// and shared structs for the gear tooth outline generator
// no dependencies
package gtog_pkg;

  localparam int PROFILE_POINTS_DEF = 5;
  localparam int CORDIC_STAGES_DEF  = 20;

  localparam int CNT_W   = 10;
  localparam int WID_W   = 16;
  localparam int SCL_W   = 16;
  localparam int IDX_W   = 10;
  localparam int CRD_W   = 32;
  localparam int SEG_W   = 3;
  localparam int CIDX_W  = 2;
  localparam int PK_W    = 4;
  localparam int WN_W    = CNT_W + WID_W;
  localparam int DEN_W   = WN_W + 8;
  localparam int NUM_W   = DEN_W + 1;
  localparam int Q_W     = 32;
  localparam int DIV_N   = NUM_W + Q_W;
  localparam int RAD_W   = 32;
  localparam int R_W     = RAD_W + 1;
  localparam int MID_W   = RAD_W + 1;
  localparam int XY_W    = 36;
  localparam int Z_W     = 33;
  localparam int V_W     = 37;
  localparam int PROD_W  = V_W + SCL_W + 1;
  localparam int QDEPTH  = 4;
  localparam int QA_W    = 2;
  localparam int SETTLE  = 5;

  localparam logic [29:0] INV_TWO_PI = 30'd683565276;
  localparam logic [30:0] HALF_PI    = 31'd1686629713;
  localparam logic [29:0] GAIN       = 30'd652032874;
  localparam int          MID_OFFSET = 131072;
  localparam int          HALF_CM    = 32768;

  typedef enum logic [CIDX_W-1:0] {
    REG_COUNT = 2'd0,
    REG_WIDTH = 2'd1,
    REG_SCALE = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [WID_W-1:0] wid;
    logic [DEN_W-1:0] den;
    logic [RAD_W-1:0] rad;
    logic [MID_W-1:0] mid;
    logic [SCL_W-1:0] scl;
    logic [CRD_W-1:0] lo;
    logic [CRD_W-1:0] hi;
  } derived_t;

  typedef struct packed {
    logic [PK_W-1:0]  k;
    logic [CRD_W-1:0] x;
    logic [CRD_W-1:0] y;
  } point_t;

  function automatic logic [16:0] prof_x(input logic [PK_W-1:0] k);
    logic [16:0] v;
    case (k)
      4'd0:    v = 17'd0;
      4'd1:    v = 17'd13107;
      4'd2:    v = 17'd45875;
      4'd3:    v = 17'd58982;
      default: v = 17'd91750;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] prof_y(input logic [PK_W-1:0] k);
    logic [15:0] v;
    case (k)
      4'd1:    v = 16'd32768;
      4'd2:    v = 16'd32768;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  function automatic logic [Z_W-1:0] atan_entry(input int i);
    logic [Z_W-1:0] v;
    case (i)
      0:       v = 33'd843314856;
      1:       v = 33'd497837829;
      2:       v = 33'd263043836;
      3:       v = 33'd133525158;
      4:       v = 33'd67021686;
      5:       v = 33'd33543515;
      6:       v = 33'd16775850;
      7:       v = 33'd8388437;
      8:       v = 33'd4194282;
      9:       v = 33'd2097149;
      default: v = (i <= 30) ? ((33'd1 << (30 - i)) - 33'd1) : 33'd0;
    endcase
    return v;
  endfunction

  // round by 1/256 and clamp to 32-bit signed
  function automatic logic [CRD_W-1:0] scale_sat(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    logic signed [PROD_W-1:0] sat_hi;
    logic signed [PROD_W-1:0] sat_lo;
    logic [CRD_W-1:0] v;
    sat_hi = PROD_W'(64'sh7fffffff);
    sat_lo = -sat_hi - PROD_W'(64'sd1);
    t = (p + PROD_W'(64'sd128)) >>> 8;
    if (t > sat_hi) begin
      v = 32'h7fffffff;
    end else if (t < sat_lo) begin
      v = 32'h80000000;
    end else begin
      v = t[CRD_W-1:0];
    end
    return v;
  endfunction

endpackage

// ===== rtl/core/gear_tooth_outline_generator.sv =====
// gear_tooth_outline_generator: the path from input transfer to first segment
// runs through the queue, the 67-step angle divider, the cordic and the scaling
// output: PROFILE_POINTS + 1 segments per tooth, one a cycle while out_tready is high
// reset: registers return to 8 teeth, width 358, scale 256; the input stays
// closed after reset and after each register write until the settle count runs out
module gear_tooth_outline_generator
  import gtog_pkg::*;
#(
  parameter int PROFILE_POINTS = PROFILE_POINTS_DEF,
  parameter int CORDIC_STAGES  = CORDIC_STAGES_DEF
)
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [15:0]        in_tdata,   // tooth_index[9:0], zero pad
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [127:0]       out_tdata,  // x_start, y_start, x_end, y_end
  output logic [SEG_W-1:0]   out_tuser,  // segment_number
  output logic               out_tlast
);

  logic             q_valid;
  logic [IDX_W-1:0] q_index;
  logic             q_pop;
  derived_t         dv;
  logic             tail_valid;
  point_t           tail;
  logic             take;

  gtog_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_index   (q_index),
    .q_pop     (q_pop),
    .dv        (dv)
  );

  gtog_point #(
    .PROFILE_POINTS (PROFILE_POINTS),
    .CORDIC_STAGES  (CORDIC_STAGES)
  ) u_point (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_index    (q_index),
    .q_pop      (q_pop),
    .dv         (dv),
    .tail_valid (tail_valid),
    .tail       (tail),
    .take       (take)
  );

  gtog_back #(
    .PROFILE_POINTS (PROFILE_POINTS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .tail_valid (tail_valid),
    .tail       (tail),
    .dv         (dv),
    .take       (take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== rtl/core/gtog_front.sv =====
// gtog_front: configuration registers, derived gear constants and the
// tooth index queue; uses gtog_pkg
module gtog_front
  import gtog_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CIDX_W-1:0]    cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [15:0]          in_tdata,
  output logic                 q_valid,
  output logic [IDX_W-1:0]     q_index,
  input  logic                 q_pop,
  output derived_t             dv
);

  logic [CNT_W-1:0]   count_r;
  logic [WID_W-1:0]   width_r;
  logic [SCL_W-1:0]   scale_r;
  logic [2:0]         settle_r;
  logic [WN_W-1:0]    wn_r;
  logic [RAD_W-1:0]   rad_r;
  logic [MID_W-1:0]   mid_r;
  logic [49:0]        lo_p_r;
  logic [49:0]        hi_p_r;
  logic [CRD_W-1:0]   lo_r;
  logic [CRD_W-1:0]   hi_r;
  logic [WN_W+29:0]   rad_p;
  logic [RAD_W-1:0]   rad_nxt;
  logic [MID_W:0]     lo_v;
  logic [MID_W:0]     hi_v;
  logic               cfg_xfer;
  logic               push;
  logic [IDX_W-1:0]   qmem [QDEPTH];
  logic [QA_W-1:0]    wr_r;
  logic [QA_W-1:0]    rd_r;
  logic [QA_W:0]      cnt_r;

  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= CNT_W'(8);
      width_r  <= WID_W'(358);
      scale_r  <= SCL_W'(256);
      settle_r <= 3'(SETTLE);
    end else begin
      if (cfg_xfer) begin
        settle_r <= 3'(SETTLE);
        case (cfg_index)
          REG_COUNT: count_r <= cfg_data[CNT_W-1:0];
          REG_WIDTH: width_r <= cfg_data[WID_W-1:0];
          REG_SCALE: scale_r <= cfg_data[SCL_W-1:0];
          default: ;
        endcase
      end else if (settle_r != 3'd0) begin
        settle_r <= settle_r - 3'd1;
      end
    end
  end

  // derived constants, four register steps
  assign rad_p   = wn_r * INV_TWO_PI;
  assign rad_nxt = RAD_W'((rad_p + (WN_W+30)'(1 << 23)) >> 24);
  assign lo_v    = (MID_W+1)'(mid_r) - (MID_W+1)'(HALF_CM);
  assign hi_v    = (MID_W+1)'(mid_r) + (MID_W+1)'(HALF_CM);

  always_ff @(posedge clk) begin
    wn_r   <= count_r * width_r;
    rad_r  <= rad_nxt;
    mid_r  <= MID_W'(rad_nxt) + MID_W'(MID_OFFSET);
    lo_p_r <= lo_v * scale_r;
    hi_p_r <= hi_v * scale_r;
    lo_r   <= scale_sat($signed(PROD_W'(lo_p_r)));
    hi_r   <= scale_sat($signed(PROD_W'(hi_p_r)));
  end

  assign dv.wid = width_r;
  assign dv.den = {wn_r, 8'd0};
  assign dv.rad = rad_r;
  assign dv.mid = mid_r;
  assign dv.scl = scale_r;
  assign dv.lo  = lo_r;
  assign dv.hi  = hi_r;

  // tooth index queue
  assign in_tready = (cnt_r != (QA_W+1)'(QDEPTH)) && (settle_r == 3'd0);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign q_index   = qmem[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wr_r] <= in_tdata[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + QA_W'(1);
      end
      if (q_pop) begin
        rd_r <= rd_r + QA_W'(1);
      end
      cnt_r <= cnt_r + (QA_W+1)'(push) - (QA_W+1)'(q_pop);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= (QA_W+1)'(QDEPTH))
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n) cfg_xfer |=> !in_tready)
    else $error("input open while constants settle");

endmodule

// ===== rtl/core/gtog_point.sv =====
// gtog_point: issues profile points per tooth and runs them through the
// angle divider, cordic and scaling pipeline; uses gtog_pkg
module gtog_point
  import gtog_pkg::*;
#(
  parameter int PROFILE_POINTS = PROFILE_POINTS_DEF,
  parameter int CORDIC_STAGES  = CORDIC_STAGES_DEF
)
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  logic [IDX_W-1:0] q_index,
  output logic             q_pop,
  input  derived_t         dv,
  output logic             tail_valid,
  output point_t           tail,
  input  logic             take
);

  localparam int S = CORDIC_STAGES;

  logic                   adv;
  logic                   issue;
  logic [PK_W-1:0]        k_r;
  logic                   den_nz;

  logic                   d_v   [DIV_N+1];
  logic [DEN_W-1:0]       d_rem [DIV_N+1];
  logic [NUM_W-1:0]       d_num [DIV_N+1];
  logic [Q_W-1:0]         d_q   [DIV_N+1];
  logic [PK_W-1:0]        d_k   [DIV_N+1];

  logic                   c_v [S+1];
  logic signed [XY_W-1:0] c_x [S+1];
  logic signed [XY_W-1:0] c_y [S+1];
  logic signed [Z_W-1:0]  c_z [S+1];
  logic [1:0]             c_q [S+1];
  logic [PK_W-1:0]        c_k [S+1];

  logic [60:0]            zp;
  logic [R_W-1:0]         rr;
  logic [62:0]            xp;

  logic                   r_v_r;
  logic signed [V_W-1:0]  r_x_r;
  logic signed [V_W-1:0]  r_y_r;
  logic [PK_W-1:0]        r_k_r;
  logic signed [XY_W-1:0] rot_x;
  logic signed [XY_W-1:0] rot_y;
  logic signed [V_W-1:0]  mid_s;

  logic                     p_v_r;
  logic signed [PROD_W-1:0] p_x_r;
  logic signed [PROD_W-1:0] p_y_r;
  logic [PK_W-1:0]          p_k_r;
  logic signed [SCL_W:0]    scl_s;

  logic                   t_v_r;
  point_t                 t_r;

  assign adv    = !t_v_r || take;
  assign issue  = q_valid && adv;
  assign q_pop  = issue && (k_r == PK_W'(PROFILE_POINTS - 1));
  assign den_nz = (dv.den != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r    <= '0;
      d_v[0] <= 1'b0;
    end else if (adv) begin
      d_v[0] <= q_valid;
      if (q_valid) begin
        k_r <= q_pop ? '0 : k_r + PK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_rem[0] <= '0;
      d_num[0] <= NUM_W'({WN_W'(q_index) * WN_W'(dv.wid), 8'd0}) + NUM_W'(prof_x(k_r));
      d_q[0]   <= '0;
      d_k[0]   <= k_r;
    end
  end

  // restoring division of num * 2^32 by den, one bit a stage
  for (genvar j = 0; j < DIV_N; j++) begin : g_div
    logic [DEN_W:0] sh;
    logic [DEN_W:0] diff;
    logic           ge;
    assign sh   = {d_rem[j], d_num[j][NUM_W-1]};
    assign diff = sh - {1'b0, dv.den};
    assign ge   = den_nz && (sh >= {1'b0, dv.den});
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d_v[j+1] <= 1'b0;
      end else if (adv) begin
        d_v[j+1] <= d_v[j];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        d_rem[j+1] <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
        d_num[j+1] <= d_num[j] << 1;
        d_q[j+1]   <= {d_q[j][Q_W-2:0], ge};
        d_k[j+1]   <= d_k[j];
      end
    end
  end

  // angle to radians and starting radius
  assign zp = d_q[DIV_N][29:0] * HALF_PI;
  assign rr = R_W'(dv.rad) + R_W'(prof_y(d_k[DIV_N]));
  assign xp = rr * GAIN;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v[0] <= 1'b0;
    end else if (adv) begin
      c_v[0] <= d_v[DIV_N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_x[0] <= $signed(XY_W'((xp + 63'(1 << 29)) >> 30));
      c_y[0] <= '0;
      c_z[0] <= $signed(Z_W'((zp + 61'(1 << 29)) >> 30));
      c_q[0] <= d_q[DIV_N][31:30];
      c_k[0] <= d_k[DIV_N];
    end
  end

  for (genvar i = 0; i < S; i++) begin : g_cordic
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic signed [Z_W-1:0]  at;
    assign dx = c_y[i] >>> i;
    assign dy = c_x[i] >>> i;
    assign at = $signed(atan_entry(i));
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        c_v[i+1] <= 1'b0;
      end else if (adv) begin
        c_v[i+1] <= c_v[i];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!c_z[i][Z_W-1]) begin
          c_x[i+1] <= c_x[i] - dx;
          c_y[i+1] <= c_y[i] + dy;
          c_z[i+1] <= c_z[i] - at;
        end else begin
          c_x[i+1] <= c_x[i] + dx;
          c_y[i+1] <= c_y[i] - dy;
          c_z[i+1] <= c_z[i] + at;
        end
        c_q[i+1] <= c_q[i];
        c_k[i+1] <= c_k[i];
      end
    end
  end

  // quadrant rotation and centre offset
  always_comb begin
    case (c_q[S])
      2'd1: begin
        rot_x = -c_y[S];
        rot_y = c_x[S];
      end
      2'd2: begin
        rot_x = -c_x[S];
        rot_y = -c_y[S];
      end
      2'd3: begin
        rot_x = c_y[S];
        rot_y = -c_x[S];
      end
      default: begin
        rot_x = c_x[S];
        rot_y = c_y[S];
      end
    endcase
  end

  assign mid_s = V_W'($signed({1'b0, dv.mid}));
  assign scl_s = $signed({1'b0, dv.scl});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_v_r <= 1'b0;
      p_v_r <= 1'b0;
      t_v_r <= 1'b0;
    end else if (adv) begin
      r_v_r <= c_v[S];
      p_v_r <= r_v_r;
      t_v_r <= p_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_x_r <= V_W'(rot_x) + mid_s;
      r_y_r <= V_W'(rot_y) + mid_s;
      r_k_r <= c_k[S];
      p_x_r <= r_x_r * scl_s;
      p_y_r <= r_y_r * scl_s;
      p_k_r <= r_k_r;
      t_r.x <= scale_sat(p_x_r);
      t_r.y <= scale_sat(p_y_r);
      t_r.k <= p_k_r;
    end
  end

  assign tail_valid = t_v_r;
  assign tail       = t_r;

endmodule

// ===== rtl/core/gtog_back.sv =====
// gtog_back: pairs consecutive profile points into segments, inserts the
// centre cross and holds the output register; uses gtog_pkg
module gtog_back
  import gtog_pkg::*;
#(
  parameter int PROFILE_POINTS = PROFILE_POINTS_DEF
)
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               tail_valid,
  input  point_t             tail,
  input  derived_t           dv,
  output logic               take,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [127:0]       out_tdata,
  output logic [SEG_W-1:0]   out_tuser,
  output logic               out_tlast
);

  logic               load;
  logic               first;
  logic               cross_r;
  logic               out_v_r;
  logic [127:0]       data_r;
  logic [SEG_W-1:0]   seg_r;
  logic               last_r;
  logic [CRD_W-1:0]   prev_x_r;
  logic [CRD_W-1:0]   prev_y_r;
  logic [PK_W-1:0]    prev_k_r;

  assign load  = !out_v_r || out_tready;
  assign first = (tail.k == '0);
  assign take  = tail_valid && load && (!first || cross_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      cross_r <= 1'b0;
    end else if (load) begin
      out_v_r <= tail_valid;
      if (tail_valid && first) begin
        cross_r <= !cross_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && tail_valid) begin
      if (first && !cross_r) begin
        data_r <= {dv.hi, dv.hi, dv.lo, dv.lo};
        seg_r  <= SEG_W'(0);
        last_r <= 1'b0;
      end else if (first) begin
        data_r <= {dv.hi, dv.lo, dv.lo, dv.hi};
        seg_r  <= SEG_W'(1);
        last_r <= 1'b0;
      end else begin
        data_r <= {tail.y, tail.x, prev_y_r, prev_x_r};
        seg_r  <= SEG_W'(tail.k + PK_W'(1));
        last_r <= (tail.k == PK_W'(PROFILE_POINTS - 1));
      end
    end
    if (take) begin
      prev_x_r <= tail.x;
      prev_y_r <= tail.y;
      prev_k_r <= tail.k;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = data_r;
  assign out_tuser  = seg_r;
  assign out_tlast  = last_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    cross_r |-> tail_valid && (tail.k == '0))
    else $error("first point lost while cross pending");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == SEG_W'(PROFILE_POINTS))
    else $error("wrong number on final segment");
  assert property (@(posedge clk) disable iff (!rst_n)
    take && (tail.k != '0) |-> prev_k_r == tail.k - PK_W'(1))
    else $error("profile points out of order");

endmodule
